/* rtl/w2s_pkg.sv */
// Shared widths, register codes and types for the world-to-screen projection unit.
package w2s_pkg;

  localparam int CW     = 21;          // world coordinate width
  localparam int OFW    = CW + 1;      // offset from view origin
  localparam int AW     = 16;          // Q1.14 axis component
  localparam int PW     = OFW + AW;    // one offset-by-axis product
  localparam int SW     = PW + 2;      // dot product of three terms
  localparam int TW     = 16;          // Q4.12 tangent
  localparam int OW     = 16;          // Q12.4 screen value
  localparam int HW     = 14;          // half screen size in Q4
  localparam int IDXW   = 3;           // register index
  localparam int DATAW  = 64;          // register write data

  localparam int DENW   = SW + TW + 1; // tangent * depth
  localparam int PRODW  = SW + HW;     // lateral * half size
  localparam int MW     = PRODW + 14;  // numerator of the rounded quotient
  localparam int DW     = DENW + 1;    // divisor, twice the denominator
  localparam int QW     = 16;          // quotient magnitude bits
  localparam int CMPW   = DW + QW;     // divider compare width
  localparam int SQW    = QW + 2;      // signed quotient plus offset

  localparam int FRONT_STAGES = 3;
  localparam int PROJ_STAGES  = 4 + QW + 1;
  localparam int LAT          = FRONT_STAGES + PROJ_STAGES;

  // depth * 100 >= 2^17 holds exactly for depth >= 1311
  localparam logic signed [SW-1:0] DEPTH_MIN = SW'(1311);
  localparam logic [HW-1:0] HALF_W_Q4 = HW'(5120);
  localparam logic [HW-1:0] HALF_H_Q4 = HW'(3840);
  localparam logic [TW-1:0] TAN_RESET = TW'(4096);

  typedef enum logic [IDXW-1:0] {
    REG_ORIGIN = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_UP     = 3'd2,
    REG_FWD    = 3'd3,
    REG_TANX   = 3'd4,
    REG_TANY   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                 vis;
    logic signed [SW-1:0] rgt;
    logic signed [SW-1:0] upv;
    logic signed [SW-1:0] dep;
  } view_vec_t;

endpackage

/* rtl/w2s_if.sv */
// Channel interfaces: point input, screen result and register write.
interface w2s_in_if;
  import w2s_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface w2s_out_if;
  import w2s_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic signed [OW-1:0] screen_x;
  logic signed [OW-1:0] screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface w2s_cfg_if;
  import w2s_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDXW-1:0]   index;
  logic [DATAW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/world_to_screen_projection_unit.sv */
// Top level: register file, view transform and two projection pipelines.
//
//   channel  dir  beat contents
//   in_ch    in   point_x, point_y, point_z (signed 21-bit, 1/8 units)
//   out_ch   out  visible, screen_x, screen_y (signed Q12.4)
//   cfg_ch   in   index (3 bits), data (64 bits); always ready
//
// One beat enters per cycle while the pipeline advances; each result passes
// through 3 transform stages, then per axis multiply, subtract, magnitude,
// range check, 16 restoring-division stages and a saturation stage.
// The whole pipeline advances while the output register is empty or taken:
// a stall holds every stage and drops nothing. Synchronous reset clears
// the valid chain and loads the register reset values.
module world_to_screen_projection_unit (
  input  logic     clk,
  input  logic     rst_n,
  w2s_in_if.sink   in_ch,
  w2s_out_if.source out_ch,
  w2s_cfg_if.sink  cfg_ch
);
  import w2s_pkg::*;

  logic [3*CW-1:0] origin_r;
  logic [3*AW-1:0] right_r;
  logic [3*AW-1:0] up_r;
  logic [3*AW-1:0] fwd_r;
  logic [TW-1:0]   tanx_r;
  logic [TW-1:0]   tany_r;

  logic            en;
  logic            vld_r [LAT];
  logic            vis_r [PROJ_STAGES];
  view_vec_t       vec;
  logic signed [OW-1:0] sx;
  logic signed [OW-1:0] sy;

  // register writes; unknown indexes fall through
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      right_r  <= '0;
      up_r     <= '0;
      fwd_r    <= '0;
      tanx_r   <= TAN_RESET;
      tany_r   <= TAN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ORIGIN: origin_r <= cfg_ch.data[3*CW-1:0];
        REG_RIGHT:  right_r  <= cfg_ch.data[3*AW-1:0];
        REG_UP:     up_r     <= cfg_ch.data[3*AW-1:0];
        REG_FWD:    fwd_r    <= cfg_ch.data[3*AW-1:0];
        REG_TANX:   tanx_r   <= cfg_ch.data[TW-1:0];
        REG_TANY:   tany_r   <= cfg_ch.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // advance everything unless a finished beat waits at the output
  assign en          = out_ch.ready | ~vld_r[LAT-1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // carry the near-plane flag alongside the projection stages
  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= vec.vis;
      for (int i = 1; i < PROJ_STAGES; i++) vis_r[i] <= vis_r[i-1];
    end
  end

  w2s_front u_front (
    .clk      (clk),
    .en       (en),
    .px       (in_ch.point_x),
    .py       (in_ch.point_y),
    .pz       (in_ch.point_z),
    .origin   (origin_r),
    .right_ax (right_r),
    .up_ax    (up_r),
    .fwd_ax   (fwd_r),
    .vec      (vec)
  );

  w2s_proj u_proj_x (
    .clk     (clk),
    .en      (en),
    .lateral (vec.rgt),
    .dep     (vec.dep),
    .tan_val (tanx_r),
    .half    (HALF_W_Q4),
    .s       (sx)
  );

  w2s_proj u_proj_y (
    .clk     (clk),
    .en      (en),
    .lateral (vec.upv),
    .dep     (vec.dep),
    .tan_val (tany_r),
    .half    (HALF_H_Q4),
    .s       (sy)
  );

  // zero the position of a point behind the near plane
  assign out_ch.valid    = vld_r[LAT-1];
  assign out_ch.visible  = vis_r[PROJ_STAGES-1];
  assign out_ch.screen_x = vis_r[PROJ_STAGES-1] ? sx : '0;
  assign out_ch.screen_y = vis_r[PROJ_STAGES-1] ? sy : '0;

endmodule

/* rtl/w2s_front.sv */
// View transform: origin offset, axis products and dot-product sums.
module w2s_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [w2s_pkg::CW-1:0] px,
  input  logic signed [w2s_pkg::CW-1:0] py,
  input  logic signed [w2s_pkg::CW-1:0] pz,
  input  logic [3*w2s_pkg::CW-1:0]      origin,
  input  logic [3*w2s_pkg::AW-1:0]      right_ax,
  input  logic [3*w2s_pkg::AW-1:0]      up_ax,
  input  logic [3*w2s_pkg::AW-1:0]      fwd_ax,
  output w2s_pkg::view_vec_t            vec
);
  import w2s_pkg::*;

  logic signed [OFW-1:0] d_r [3];
  logic signed [PW-1:0]  pr_r [3];
  logic signed [PW-1:0]  pu_r [3];
  logic signed [PW-1:0]  pf_r [3];
  view_vec_t             vec_r;
  logic signed [CW-1:0]  pt [3];
  logic signed [SW-1:0]  dep_sum;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]  <= OFW'(pt[k]) - OFW'($signed(origin[k*CW +: CW]));
        pr_r[k] <= PW'(d_r[k]) * PW'($signed(right_ax[k*AW +: AW]));
        pu_r[k] <= PW'(d_r[k]) * PW'($signed(up_ax[k*AW +: AW]));
        pf_r[k] <= PW'(d_r[k]) * PW'($signed(fwd_ax[k*AW +: AW]));
      end
      vec_r.rgt <= SW'(pr_r[0]) + SW'(pr_r[1]) + SW'(pr_r[2]);
      vec_r.upv <= SW'(pu_r[0]) + SW'(pu_r[1]) + SW'(pu_r[2]);
      vec_r.dep <= dep_sum;
      vec_r.vis <= (dep_sum >= DEPTH_MIN);
    end
  end

  assign dep_sum = SW'(pf_r[0]) + SW'(pf_r[1]) + SW'(pf_r[2]);
  assign vec     = vec_r;

endmodule

/* rtl/w2s_proj.sv */
// One screen axis: scale, rounded floor quotient by restoring division, saturate.
module w2s_proj (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [w2s_pkg::SW-1:0] lateral,
  input  logic signed [w2s_pkg::SW-1:0] dep,
  input  logic [w2s_pkg::TW-1:0]        tan_val,
  input  logic [w2s_pkg::HW-1:0]        half,
  output logic signed [w2s_pkg::OW-1:0] s
);
  import w2s_pkg::*;

  logic [TW-1:0]            t_eff;
  logic signed [DENW-1:0]   den_r;
  logic signed [PRODW-1:0]  prod_r;
  logic signed [MW-1:0]     m_r;
  logic [DW-1:0]            dd5_r;
  logic [MW-1:0]            mag_r;
  logic                     neg6_r;
  logic [DW-1:0]            dd6_r;

  logic [MW-1:0]            r_s   [QW+1];
  logic [DW-1:0]            dd_s  [QW+1];
  logic [QW-1:0]            q_s   [QW+1];
  logic                     neg_s [QW+1];
  logic                     ovf_s [QW+1];

  logic signed [SQW-1:0]    qs;
  logic signed [SQW-1:0]    s_full;
  logic signed [OW-1:0]     s_nxt;
  logic signed [OW-1:0]     s_r;

  assign t_eff = (tan_val == '0) ? TW'(1) : tan_val;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= DENW'($signed({1'b0, t_eff})) * DENW'(dep);
      prod_r <= PRODW'(lateral) * PRODW'($signed({1'b0, half}));
      m_r    <= MW'(den_r) - (MW'(prod_r) <<< 13);
      dd5_r  <= {1'b0, den_r[DENW-2:0], 1'b0};
      mag_r  <= m_r[MW-1] ? MW'(-m_r) : MW'(m_r);
      neg6_r <= m_r[MW-1];
      dd6_r  <= dd5_r;
      r_s[0]   <= mag_r;
      dd_s[0]  <= dd6_r;
      q_s[0]   <= '0;
      neg_s[0] <= neg6_r;
      ovf_s[0] <= CMPW'(mag_r) >= (CMPW'(dd6_r) << QW);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [CMPW-1:0] sh;
    logic            ge;
    assign sh = CMPW'(dd_s[j]) << B;
    assign ge = CMPW'(r_s[j]) >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[j+1]   <= ge ? MW'(CMPW'(r_s[j]) - sh) : r_s[j];
        q_s[j+1]   <= q_s[j] | (QW'(ge) << B);
        dd_s[j+1]  <= dd_s[j];
        neg_s[j+1] <= neg_s[j];
        ovf_s[j+1] <= ovf_s[j];
      end
    end
  end

  // floor of a negative quotient rounds the magnitude up
  always_comb begin
    if (neg_s[QW]) begin
      qs = -(SQW'(q_s[QW]) + SQW'(r_s[QW] != '0));
    end else begin
      qs = SQW'(q_s[QW]);
    end
    s_full = SQW'(half) + qs;
    if (ovf_s[QW]) begin
      s_nxt = neg_s[QW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else if (s_full > SQW'(32767)) begin
      s_nxt = {1'b0, {(OW-1){1'b1}}};
    end else if (s_full < -SQW'(32768)) begin
      s_nxt = {1'b1, {(OW-1){1'b0}}};
    end else begin
      s_nxt = OW'(s_full);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s = s_r;

endmodule
